[src/hhm_pkg.sv]
package hhm_pkg;

    localparam int HYD_W     = 13;
    localparam int WGT_W     = 14;
    localparam int TRIG_W    = 16;
    localparam int PROD_W    = WGT_W + TRIG_W;
    localparam int SUM_W     = 32;
    localparam int STEP_W    = 5;
    localparam int MOMENT_W  = 16;
    localparam int SQ_W      = 2 * SUM_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int CNT_W     = $clog2(ROOT_W);
    localparam int FRAC_BITS = 14;

    localparam logic [STEP_W-1:0] TRIG_LAST = STEP_W'(17);
    localparam logic signed [WGT_W-1:0] HYD_OFFSET = WGT_W'(3149);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic sq_x;
        logic sq_y;
        logic sq_sum;
        logic root_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_last;
        logic root_last;
        logic out_full;
    } t_sts;

    function automatic logic signed [TRIG_W-1:0] trig_cos(input logic [STEP_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        unique case (idx)
            5'd1:    v = -16'sd2845;
            5'd2:    v = -16'sd15396;
            5'd3:    v = 16'sd8192;
            5'd4:    v = 16'sd12551;
            5'd5:    v = -16'sd12551;
            5'd6:    v = -16'sd8192;
            5'd7:    v = 16'sd15396;
            5'd8:    v = 16'sd2845;
            5'd9:    v = -16'sd16384;
            5'd10:   v = 16'sd2845;
            5'd11:   v = 16'sd15396;
            5'd12:   v = -16'sd8192;
            5'd13:   v = -16'sd12551;
            5'd14:   v = 16'sd12551;
            5'd15:   v = 16'sd8192;
            5'd16:   v = -16'sd15396;
            5'd17:   v = -16'sd2845;
            default: v = 16'sd16384;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] trig_sin(input logic [STEP_W-1:0] idx);
        logic signed [TRIG_W-1:0] v;
        unique case (idx)
            5'd1:    v = 16'sd16135;
            5'd2:    v = -16'sd5604;
            5'd3:    v = -16'sd14189;
            5'd4:    v = 16'sd10531;
            5'd5:    v = 16'sd10531;
            5'd6:    v = -16'sd14189;
            5'd7:    v = -16'sd5604;
            5'd8:    v = 16'sd16135;
            5'd9:    v = 16'sd0;
            5'd10:   v = -16'sd16135;
            5'd11:   v = 16'sd5604;
            5'd12:   v = 16'sd14189;
            5'd13:   v = -16'sd10531;
            5'd14:   v = -16'sd10531;
            5'd15:   v = 16'sd14189;
            5'd16:   v = 16'sd5604;
            5'd17:   v = -16'sd16135;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/hhm_ctrl.sv]
module hhm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hhm_pkg::t_sts i_sts,
    output hhm_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_SQX  = 8'b0000_1000,
        S_SQY  = 8'b0001_0000,
        S_SUM  = 8'b0010_0000,
        S_ROOT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.in_last ? S_SQX : S_IDLE;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sq_sum = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.root_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[src/hhm_dp.sv]
module hhm_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hhm_pkg::t_cmd                          i_cmd,
    output hhm_pkg::t_sts                          o_sts,
    input  logic signed [hhm_pkg::HYD_W-1:0]       i_hydrophobicity,
    input  logic                                   i_last,
    output logic [hhm_pkg::MOMENT_W-1:0]           o_moment,
    output logic                                   o_valid,
    input  logic                                   i_ready
);

    localparam int SX_W = hhm_pkg::SUM_W + 1;
    localparam logic signed [SX_W-1:0] SUM_MAX = SX_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [SX_W-1:0] SUM_MIN = -SX_W'(33'sh0_8000_0000);

    logic signed [hhm_pkg::HYD_W-1:0]   r_hyd;
    logic                               r_last;
    logic signed [hhm_pkg::PROD_W-1:0]  r_p_cos;
    logic signed [hhm_pkg::PROD_W-1:0]  r_p_sin;
    logic signed [hhm_pkg::SUM_W-1:0]   r_sum_cos;
    logic signed [hhm_pkg::SUM_W-1:0]   r_sum_sin;
    logic [hhm_pkg::STEP_W-1:0]         r_step;
    logic [hhm_pkg::SQ_W-1:0]           r_prod;
    logic [hhm_pkg::SQ_W-1:0]           r_rad;
    logic [hhm_pkg::REM_W-1:0]          r_rem;
    logic [hhm_pkg::ROOT_W-1:0]         r_root;
    logic [hhm_pkg::CNT_W-1:0]          r_cnt;
    logic [hhm_pkg::MOMENT_W-1:0]       r_moment;
    logic                               r_out_valid;

    logic signed [hhm_pkg::WGT_W-1:0]   wgt;
    logic signed [hhm_pkg::PROD_W-1:0]  term_cos;
    logic signed [hhm_pkg::PROD_W-1:0]  term_sin;
    logic signed [SX_W-1:0]             add_cos;
    logic signed [SX_W-1:0]             add_sin;
    logic signed [SX_W-1:0]             sat_cos;
    logic signed [SX_W-1:0]             sat_sin;
    logic [hhm_pkg::SUM_W-1:0]          abs_x;
    logic [hhm_pkg::SUM_W-1:0]          abs_y;
    logic [hhm_pkg::SUM_W-1:0]          mul_op;
    logic [hhm_pkg::REM_W+1:0]          rem_sh;
    logic [hhm_pkg::REM_W+1:0]          trial;
    logic [hhm_pkg::REM_W+1:0]          rem_sub;
    logic [hhm_pkg::MOMENT_W-1:0]       mag_sat;

    assign wgt = hhm_pkg::WGT_W'(r_hyd) + hhm_pkg::HYD_OFFSET;

    // Round half up: floor((p + 8) / 16)
    assign term_cos = (r_p_cos + hhm_pkg::PROD_W'(8)) >>> 4;
    assign term_sin = (r_p_sin + hhm_pkg::PROD_W'(8)) >>> 4;

    assign add_cos = SX_W'(r_sum_cos) + SX_W'(term_cos);
    assign add_sin = SX_W'(r_sum_sin) + SX_W'(term_sin);

    always_comb begin
        sat_cos = add_cos;
        if (add_cos > SUM_MAX) sat_cos = SUM_MAX;
        if (add_cos < SUM_MIN) sat_cos = SUM_MIN;
        sat_sin = add_sin;
        if (add_sin > SUM_MAX) sat_sin = SUM_MAX;
        if (add_sin < SUM_MIN) sat_sin = SUM_MIN;
    end

    assign abs_x  = r_sum_cos[hhm_pkg::SUM_W-1] ? (~r_sum_cos + 1'b1) : r_sum_cos;
    assign abs_y  = r_sum_sin[hhm_pkg::SUM_W-1] ? (~r_sum_sin + 1'b1) : r_sum_sin;
    assign mul_op = i_cmd.sq_y ? abs_y : abs_x;

    // One root bit per step: bring down two radicand bits, try root*4+1
    assign rem_sh  = {r_rem, r_rad[hhm_pkg::SQ_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;

    assign mag_sat = (|r_root[hhm_pkg::ROOT_W-1:hhm_pkg::FRAC_BITS+hhm_pkg::MOMENT_W])
                     ? '1
                     : r_root[hhm_pkg::FRAC_BITS +: hhm_pkg::MOMENT_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_hyd  <= i_hydrophobicity;
            r_last <= i_last;
        end
        if (i_cmd.mul) begin
            r_p_cos <= wgt * hhm_pkg::trig_cos(r_step);
            r_p_sin <= wgt * hhm_pkg::trig_sin(r_step);
        end
        if (i_cmd.sq_x || i_cmd.sq_y) begin
            r_prod <= mul_op * mul_op;
        end
        if (i_cmd.sq_y) begin
            r_rad <= r_prod;
        end else if (i_cmd.sq_sum) begin
            r_rad <= r_rad + r_prod;
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
        end
        if (i_cmd.sq_sum) begin
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.root_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sub[hhm_pkg::REM_W-1:0];
                r_root <= {r_root[hhm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[hhm_pkg::REM_W-1:0];
                r_root <= {r_root[hhm_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_moment <= mag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_cos   <= '0;
            r_sum_sin   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum_cos <= hhm_pkg::SUM_W'(sat_cos);
                r_sum_sin <= hhm_pkg::SUM_W'(sat_sin);
                // A step past the table is taken as step 0
                if (r_last || r_step == hhm_pkg::TRIG_LAST) begin
                    r_step <= '0;
                end else if (r_step > hhm_pkg::TRIG_LAST) begin
                    r_step <= hhm_pkg::STEP_W'(1);
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end else if (i_cmd.sq_y) begin
                r_sum_cos <= '0;
                r_sum_sin <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_last   = r_last;
    assign o_sts.root_last = (r_cnt == hhm_pkg::CNT_W'(hhm_pkg::ROOT_W - 1));
    assign o_sts.out_full  = r_out_valid && !i_ready;

    assign o_moment = r_moment;
    assign o_valid  = r_out_valid;

endmodule

[src/helical_hydrophobic_moment_top.sv]
// Sequence: a residue passes through accept, multiply and accumulate; a last residue
// then shows its moment on o_valid after two squarings on the shared 32x32 multiplier,
// the sum of squares, the 32-step bit-serial square root and the result load.
// A new residue is accepted only once the previous one is accumulated (after a last one, once its result is loaded).
// Reset (synchronous, active low) clears both sums, the angle step, the controller
// state and the output valid; payload registers are not reset.
module helical_hydrophobic_moment_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [hhm_pkg::HYD_W-1:0]       i_hydrophobicity,
    input  logic                                   i_last,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [hhm_pkg::MOMENT_W-1:0]           o_moment
);

    hhm_pkg::t_cmd cmd;
    hhm_pkg::t_sts sts;

    // Controller: sequence accept, multiply, accumulate, square, root and result load
    hhm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: trig-weighted saturating sums, shared squarer, restoring root.
    // The result sits in an output register, so a new segment may start while
    // the previous moment still waits for its transfer.
    hhm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_hydrophobicity (i_hydrophobicity),
        .i_last           (i_last),
        .o_moment         (o_moment),
        .o_valid          (o_valid),
        .i_ready          (i_ready)
    );

    // A transfer in keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready high right after an input transfer");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_valid && !i_ready))
        else $error("result loaded over a pending one");

    // At most one datapath step at a time
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_in, cmd.mul, cmd.acc, cmd.sq_x, cmd.sq_y,
                  cmd.sq_sum, cmd.root_step, cmd.load_out}))
        else $error("more than one datapath command");

    // A result is loaded only after the root finishes
    a_load_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !cmd.root_step && !$past(cmd.sq_sum))
        else $error("result loaded before root done");

endmodule
